[src/mexp_pkg.sv]
// shared types for the modular exponentiation unit
// no dependencies; imported by the top level sequencer
package mexp_pkg;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RESID = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_SQR   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

[src/mexp_resid.sv]
// bit-serial residue of a signed base modulo an unsigned modulus
// standalone; used by modular_exponentiation_unit
module mexp_resid #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [OPERAND_WIDTH-1:0]   base_raw,
	input  logic [OPERAND_WIDTH-2:0]   modulus,
	output logic                       done,
	output logic [OPERAND_WIDTH-2:0]   residue
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = OPERAND_WIDTH - 1;
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  mag_q;
	logic [W-1:0]  r_q;
	logic [MW-1:0] m_q;

	logic [W-1:0]  shifted;
	logic [W-1:0]  m_ext;
	logic [W-1:0]  r_next;
	logic [MW-1:0] lifted;

	// one restoring step: bring in the next magnitude bit, subtract if over
	assign shifted = {r_q[W-2:0], mag_q[W-1]};
	assign m_ext   = {1'b0, m_q};
	assign r_next  = (shifted >= m_ext) ? (shifted - m_ext) : shifted;

	// negative bases map a nonzero remainder to modulus minus remainder
	assign lifted = (neg_q && (r_q[MW-1:0] != '0)) ? (m_q - r_q[MW-1:0]) : r_q[MW-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= base_raw[W-1];
			mag_q <= base_raw[W-1] ? (~base_raw + 1'b1) : base_raw;
			r_q   <= '0;
			m_q   <= modulus;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				r_q <= {1'b0, lifted};
			end else begin
				r_q   <= r_next;
				mag_q <= {mag_q[W-2:0], 1'b0};
			end
		end
	end

	assign done    = done_q;
	assign residue = r_q[MW-1:0];

endmodule

[src/mexp_modmul.sv]
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// standalone; used by modular_exponentiation_unit
module mexp_modmul #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [OPERAND_WIDTH-2:0]   x,
	input  logic [OPERAND_WIDTH-2:0]   y,
	input  logic [OPERAND_WIDTH-2:0]   modulus,
	output logic                       done,
	output logic [OPERAND_WIDTH-2:0]   product
);

	localparam int MW = OPERAND_WIDTH - 1;
	localparam int CW = $clog2(MW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] acc_q;
	logic [MW-1:0] x_q;
	logic [MW-1:0] y_q;
	logic [MW-1:0] m_q;

	logic [MW+1:0] t;
	logic [MW+2:0] d1;
	logic [MW+2:0] d2;
	logic [MW-1:0] acc_next;

	// double the accumulator, add x when the multiplier bit is set;
	// the sum stays below three times the modulus
	assign t  = {1'b0, acc_q, 1'b0} + {2'b00, (y_q[MW-1] ? x_q : {MW{1'b0}})};
	assign d1 = {1'b0, t} - {3'b000, m_q};
	assign d2 = {1'b0, t} - {2'b00, m_q, 1'b0};

	// pick the reduced value with parallel subtractions
	always_comb begin
		priority if (!d2[MW+2]) begin
			acc_next = d2[MW-1:0];
		end else if (!d1[MW+2]) begin
			acc_next = d1[MW-1:0];
		end else begin
			acc_next = t[MW-1:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, multiplier scanned from the top bit
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= modulus;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[MW-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[src/modular_exponentiation_unit.sv]
// modular exponentiation, right-to-left square and multiply, one item at a time
// steps: base residue, then one modular multiply per set exponent bit and one square
// per bit below the top, then the output register
// a zero exponent or zero modulus skips the residue and multiplies and goes to the output
// the single shared bit-serial multiplier does every multiply and square in turn
// reset: asynchronous, active low; clears the sequencer and the output valid
module modular_exponentiation_unit
	import mexp_pkg::*;
#(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [OPERAND_WIDTH-1:0]   base_value,
	input  logic        [OPERAND_WIDTH-2:0]   exponent_value,
	input  logic        [OPERAND_WIDTH-2:0]   modulus_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic        [OPERAND_WIDTH-2:0]   power_result
);

	localparam int MW = OPERAND_WIDTH - 1;

	state_t        state_q;
	logic          mul_start_q;
	logic          mul_sq_q;
	logic          out_valid_q;
	logic [MW-1:0] e_q;
	logic [MW-1:0] m_q;
	logic [MW-1:0] res_q;
	logic [MW-1:0] pow_q;
	logic [MW-1:0] out_q;

	logic          in_xfer;
	logic          load_out;
	logic          resid_start;
	logic          resid_done;
	logic [MW-1:0] resid_val;
	logic          mul_done;
	logic [MW-1:0] mul_y;
	logic [MW-1:0] mul_prod;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && (state_q == ST_IDLE);
	assign resid_start = in_xfer && (exponent_value != '0) && (modulus_value != '0);
	assign load_out    = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign mul_y       = mul_sq_q ? pow_q : res_q;

	// base residue
	mexp_resid #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_resid (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (resid_start),
		.base_raw (base_value),
		.modulus  (modulus_value),
		.done     (resid_done),
		.residue  (resid_val)
	);

	// shared multiplier for both multiply and square
	mexp_modmul #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.x       (pow_q),
		.y       (mul_y),
		.modulus (m_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			mul_sq_q    <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= resid_start ? ST_RESID : ST_OUT;
					end
				end
				ST_RESID: begin
					if (resid_done) begin
						mul_start_q <= 1'b1;
						mul_sq_q    <= !e_q[0];
						state_q     <= e_q[0] ? ST_MUL : ST_SQR;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (e_q[MW-1:1] == '0) begin
							state_q <= ST_OUT;
						end else begin
							mul_start_q <= 1'b1;
							mul_sq_q    <= 1'b1;
							state_q     <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						mul_sq_q    <= !e_q[1];
						state_q     <= e_q[1] ? ST_MUL : ST_SQR;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// exponent, modulus, running result and power
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			e_q <= exponent_value;
			m_q <= modulus_value;
			if (exponent_value == '0) begin
				res_q <= MW'(1);
			end else if ((modulus_value == '0) || (modulus_value == MW'(1))) begin
				res_q <= '0;
			end else begin
				res_q <= MW'(1);
			end
		end
		if ((state_q == ST_RESID) && resid_done) begin
			pow_q <= resid_val;
		end
		if ((state_q == ST_MUL) && mul_done) begin
			res_q <= mul_prod;
		end
		if ((state_q == ST_SQR) && mul_done) begin
			pow_q <= mul_prod;
			e_q   <= {1'b0, e_q[MW-1:1]};
		end
	end

	// output register, freed by a transfer on the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = out_q;

endmodule
